// ===== design/sesm_pkg.sv =====
package sesm_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam logic [31:0] VAL_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_COMPRESS = 2'd1,
    KIND_DIVIDE   = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_LOADI,
    ST_S_GETI,
    ST_S_SHIFT,
    ST_S_PLACE,
    ST_M_START,
    ST_M_FIRST,
    ST_M_RUN,
    ST_M_END,
    ST_R_READ,
    ST_R_LOAD,
    ST_R_HOLD,
    ST_D_READ,
    ST_D_LOAD,
    ST_D_RUN
  } state_t;

  typedef struct packed {
    logic [31:0] idx;
    logic [31:0] val;
  } entry_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

endpackage

// ===== design/sesm_store.sv =====
module sesm_store #(
  parameter int CAPACITY = sesm_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  sesm_pkg::entry_t  wr_data,
  input  logic [AW-1:0]     rd_addr,
  output sesm_pkg::entry_t  rd_data
);

  sesm_pkg::entry_t mem [CAPACITY];
  sesm_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/sesm_div.sv =====
module sesm_div #(
  parameter int FRAC_BITS = sesm_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         dividend,
  input  logic [31:0]         divisor,
  output logic [31:0]         quotient,
  output sesm_pkg::div_stat_t stat
);

  localparam int DW   = 32 + FRAC_BITS;
  localparam int CNTW = $clog2(DW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]   dvd_r, dvd_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [31:0]     quo_r, quo_nxt;
  logic            hi_r, hi_nxt;
  logic [32:0]     trial;
  logic            ge;
  logic [32:0]     diff;

  always_comb begin
    trial    = {rem_r, dvd_r[DW-1]};
    ge       = trial >= {1'b0, divisor};
    diff     = trial - {1'b0, divisor};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    hi_nxt   = hi_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = DW'(dividend) << FRAC_BITS;
      rem_nxt  = '0;
      quo_nxt  = '0;
      hi_nxt   = 1'b0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[31:0] : trial[31:0];
      quo_nxt = {quo_r[30:0], ge};
      hi_nxt  = hi_r | quo_r[31];
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r + CNTW'(1);
      if (cnt_r == CNTW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    hi_r  <= hi_nxt;
  end

  assign quotient  = quo_r;
  assign stat.done = done_r;
  assign stat.sat  = hi_r;

endmodule

// ===== design/sparse_entry_sort_merge_top.sv =====
// add and clear: a new request every cycle while idle
// compress: unless already sorted, insertion sort in the store, then a merge pass that sums
//   entries of equal index, then the results are read out of the store one at a time
// divide: each stored entry in turn, through the bit-serial divider
// synchronous active-low reset empties the store and clears both sticky flags
module sparse_entry_sort_merge_top #(
  parameter int CAPACITY  = sesm_pkg::CAPACITY_DEF,
  parameter int FRAC_BITS = sesm_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_entry_index,
  input  logic [31:0] in_operand_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_index,
  output logic [31:0] out_value,
  output logic        out_last_entry,
  output logic        out_is_empty,
  output logic        out_overflowed,
  output logic        out_saturated
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  sesm_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]    count_r, count_nxt;
  logic             sorted_r, sorted_nxt;
  logic             ovf_r, ovf_nxt;
  logic             sat_r, sat_nxt;
  logic [31:0]      last_idx_r, last_idx_nxt;
  logic [AW-1:0]    si_r, si_nxt;
  logic [AW-1:0]    sj_r, sj_nxt;
  logic [CW-1:0]    mi_r, mi_nxt;
  logic [AW-1:0]    mw_r, mw_nxt;
  sesm_pkg::entry_t key_r, key_nxt;
  sesm_pkg::entry_t acc_r, acc_nxt;
  logic [31:0]      divisor_r, divisor_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [31:0]      oidx_r, oidx_nxt;
  logic [31:0]      oval_r, oval_nxt;
  logic             olast_r, olast_nxt;
  logic             oempty_r, oempty_nxt;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  sesm_pkg::entry_t wr_data;
  logic [AW-1:0]    rd_addr;
  sesm_pkg::entry_t rd_data;

  logic             div_start;
  logic [31:0]      div_quo;
  sesm_pkg::div_stat_t div_stat;

  logic             in_acc;
  logic [32:0]      sum;
  logic             si_more;
  logic             di_more;
  sesm_pkg::kind_t  kind;

  assign in_acc  = in_valid && in_ready;
  assign kind    = sesm_pkg::kind_t'(in_kind);
  assign sum     = {1'b0, acc_r.val} + {1'b0, rd_data.val};
  assign si_more = (CW'(si_r) + CW'(1)) < count_r;
  assign di_more = (CW'(si_r) + CW'(1)) < count_r;

  sesm_store #(.CAPACITY(CAPACITY)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sesm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data.val),
    .divisor  (divisor_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sesm_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (kind)
            sesm_pkg::KIND_COMPRESS: begin
              state_nxt = sorted_r ? sesm_pkg::ST_R_READ : sesm_pkg::ST_S_LOADI;
            end
            sesm_pkg::KIND_DIVIDE: begin
              if (count_r != '0) begin
                state_nxt = sesm_pkg::ST_D_READ;
              end
            end
            default: state_nxt = sesm_pkg::ST_IDLE;
          endcase
        end
      end
      sesm_pkg::ST_S_LOADI: state_nxt = sesm_pkg::ST_S_GETI;
      sesm_pkg::ST_S_GETI:  state_nxt = sesm_pkg::ST_S_SHIFT;
      sesm_pkg::ST_S_SHIFT: begin
        if (rd_data.idx > key_r.idx) begin
          if (sj_r == AW'(1)) begin
            state_nxt = sesm_pkg::ST_S_PLACE;
          end
        end else begin
          state_nxt = si_more ? sesm_pkg::ST_S_LOADI : sesm_pkg::ST_M_START;
        end
      end
      sesm_pkg::ST_S_PLACE: begin
        state_nxt = si_more ? sesm_pkg::ST_S_LOADI : sesm_pkg::ST_M_START;
      end
      sesm_pkg::ST_M_START: state_nxt = sesm_pkg::ST_M_FIRST;
      sesm_pkg::ST_M_FIRST: state_nxt = sesm_pkg::ST_M_RUN;
      sesm_pkg::ST_M_RUN: begin
        if (mi_r == count_r - CW'(1)) begin
          state_nxt = sesm_pkg::ST_M_END;
        end
      end
      sesm_pkg::ST_M_END:  state_nxt = sesm_pkg::ST_R_READ;
      sesm_pkg::ST_R_READ: state_nxt = sesm_pkg::ST_R_LOAD;
      sesm_pkg::ST_R_LOAD: state_nxt = sesm_pkg::ST_R_HOLD;
      sesm_pkg::ST_R_HOLD: begin
        if (out_ready) begin
          state_nxt = olast_r ? sesm_pkg::ST_IDLE : sesm_pkg::ST_R_READ;
        end
      end
      sesm_pkg::ST_D_READ: state_nxt = sesm_pkg::ST_D_LOAD;
      sesm_pkg::ST_D_LOAD: begin
        if (divisor_r == '0) begin
          state_nxt = di_more ? sesm_pkg::ST_D_READ : sesm_pkg::ST_IDLE;
        end else begin
          state_nxt = sesm_pkg::ST_D_RUN;
        end
      end
      sesm_pkg::ST_D_RUN: begin
        if (div_stat.done) begin
          state_nxt = di_more ? sesm_pkg::ST_D_READ : sesm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sesm_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt    = count_r;
    sorted_nxt   = sorted_r;
    ovf_nxt      = ovf_r;
    sat_nxt      = sat_r;
    last_idx_nxt = last_idx_r;
    si_nxt       = si_r;
    sj_nxt       = sj_r;
    mi_nxt       = mi_r;
    mw_nxt       = mw_r;
    key_nxt      = key_r;
    acc_nxt      = acc_r;
    divisor_nxt  = divisor_r;
    ovalid_nxt   = ovalid_r;
    oidx_nxt     = oidx_r;
    oval_nxt     = oval_r;
    olast_nxt    = olast_r;
    oempty_nxt   = oempty_r;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = key_r;
    rd_addr      = '0;
    div_start    = 1'b0;
    in_ready     = (state_r == sesm_pkg::ST_IDLE);
    unique case (state_r)
      sesm_pkg::ST_IDLE: begin
        si_nxt = '0;
        if (in_acc) begin
          unique case (kind)
            sesm_pkg::KIND_ADD: begin
              if (count_r == CW'(CAPACITY)) begin
                ovf_nxt = 1'b1;
              end else begin
                wr_en       = 1'b1;
                wr_addr     = count_r[AW-1:0];
                wr_data.idx = in_entry_index;
                wr_data.val = in_operand_value;
                if (count_r != '0 && !(last_idx_r < in_entry_index)) begin
                  sorted_nxt = 1'b0;
                end
                last_idx_nxt = in_entry_index;
                count_nxt    = count_r + CW'(1);
              end
            end
            sesm_pkg::KIND_COMPRESS: begin
              si_nxt = sorted_r ? AW'(0) : AW'(1);
            end
            sesm_pkg::KIND_DIVIDE: begin
              divisor_nxt = in_operand_value;
              if (in_operand_value == '0) begin
                sat_nxt = 1'b1;
              end
            end
            sesm_pkg::KIND_CLEAR: begin
              count_nxt  = '0;
              sorted_nxt = 1'b1;
              ovf_nxt    = 1'b0;
              sat_nxt    = 1'b0;
            end
            default: ;
          endcase
        end
      end
      sesm_pkg::ST_S_LOADI: rd_addr = si_r;
      sesm_pkg::ST_S_GETI: begin
        key_nxt = rd_data;
        sj_nxt  = si_r;
        rd_addr = si_r - AW'(1);
      end
      sesm_pkg::ST_S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = sj_r;
        if (rd_data.idx > key_r.idx) begin
          wr_data = rd_data;
          sj_nxt  = sj_r - AW'(1);
          rd_addr = sj_r - AW'(2);
        end else begin
          wr_data = key_r;
          si_nxt  = si_r + AW'(1);
        end
      end
      sesm_pkg::ST_S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = sj_r;
        wr_data = key_r;
        si_nxt  = si_r + AW'(1);
      end
      sesm_pkg::ST_M_START: rd_addr = '0;
      sesm_pkg::ST_M_FIRST: begin
        acc_nxt = rd_data;
        rd_addr = AW'(1);
        mi_nxt  = CW'(1);
        mw_nxt  = '0;
      end
      sesm_pkg::ST_M_RUN: begin
        if (rd_data.idx == acc_r.idx) begin
          if (sum[32]) begin
            acc_nxt.val = sesm_pkg::VAL_MAX;
            sat_nxt     = 1'b1;
          end else begin
            acc_nxt.val = sum[31:0];
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = mw_r;
          wr_data = acc_r;
          mw_nxt  = mw_r + AW'(1);
          acc_nxt = rd_data;
        end
        rd_addr = mi_r[AW-1:0] + AW'(1);
        mi_nxt  = mi_r + CW'(1);
      end
      sesm_pkg::ST_M_END: begin
        wr_en        = 1'b1;
        wr_addr      = mw_r;
        wr_data      = acc_r;
        count_nxt    = CW'(mw_r) + CW'(1);
        last_idx_nxt = acc_r.idx;
        sorted_nxt   = 1'b1;
        si_nxt       = '0;
      end
      sesm_pkg::ST_R_READ: rd_addr = si_r;
      sesm_pkg::ST_R_LOAD: begin
        ovalid_nxt = 1'b1;
        if (count_r == '0) begin
          oidx_nxt   = '0;
          oval_nxt   = '0;
          olast_nxt  = 1'b1;
          oempty_nxt = 1'b1;
        end else begin
          oidx_nxt   = rd_data.idx;
          oval_nxt   = rd_data.val;
          olast_nxt  = !si_more;
          oempty_nxt = 1'b0;
        end
      end
      sesm_pkg::ST_R_HOLD: begin
        if (out_ready) begin
          ovalid_nxt = 1'b0;
          si_nxt     = si_r + AW'(1);
        end
      end
      sesm_pkg::ST_D_READ: rd_addr = si_r;
      sesm_pkg::ST_D_LOAD: begin
        key_nxt = rd_data;
        if (divisor_r == '0) begin
          wr_en       = 1'b1;
          wr_addr     = si_r;
          wr_data.idx = rd_data.idx;
          wr_data.val = sesm_pkg::VAL_MAX;
          si_nxt      = si_r + AW'(1);
        end else begin
          div_start = 1'b1;
        end
      end
      sesm_pkg::ST_D_RUN: begin
        if (div_stat.done) begin
          wr_en       = 1'b1;
          wr_addr     = si_r;
          wr_data.idx = key_r.idx;
          wr_data.val = div_stat.sat ? sesm_pkg::VAL_MAX : div_quo;
          if (div_stat.sat) begin
            sat_nxt = 1'b1;
          end
          si_nxt = si_r + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sesm_pkg::ST_IDLE;
      count_r  <= '0;
      sorted_r <= 1'b1;
      ovf_r    <= 1'b0;
      sat_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      sorted_r <= sorted_nxt;
      ovf_r    <= ovf_nxt;
      sat_r    <= sat_nxt;
      ovalid_r <= ovalid_nxt;
    end
    last_idx_r <= last_idx_nxt;
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    mi_r       <= mi_nxt;
    mw_r       <= mw_nxt;
    key_r      <= key_nxt;
    acc_r      <= acc_nxt;
    divisor_r  <= divisor_nxt;
    oidx_r     <= oidx_nxt;
    oval_r     <= oval_nxt;
    olast_r    <= olast_nxt;
    oempty_r   <= oempty_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_index      = oidx_r;
  assign out_value      = oval_r;
  assign out_last_entry = olast_r;
  assign out_is_empty   = oempty_r;
  assign out_overflowed = ovf_r;
  assign out_saturated  = sat_r;

endmodule

// ===== design/sesm_checker.sv =====
module sesm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_index,
  input logic [31:0] out_value,
  input logic        out_last_entry,
  input logic        out_is_empty,
  input logic        out_overflowed,
  input logic        out_saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_value)
      && $stable(out_last_entry) && $stable(out_is_empty)
      && $stable(out_overflowed) && $stable(out_saturated))
    else $error("result changed while stalled");

  a_busy_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken during readout");

  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_last_entry && out_index == '0 && out_value == '0)
    else $error("malformed empty result");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == sesm_pkg::KIND_CLEAR || in_kind == sesm_pkg::KIND_ADD)
    |=> in_ready && !out_valid)
    else $error("not idle after add or clear");

endmodule

bind sparse_entry_sort_merge_top sesm_checker u_sesm_checker (.*);
